### hdl/pixel_color_filter_top_defines.svh
// ---------------------------------------------------------------------------
// pixel_color_filter_top_defines
// Assertion macros for the pixel colour filter.
// ---------------------------------------------------------------------------
`ifndef PIXEL_COLOR_FILTER_TOP_DEFINES_SVH
`define PIXEL_COLOR_FILTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PCF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies a delayed consequent
`define PCF_ASSERT_DLY2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##2 (cons)) else $error(msg);

`endif

### hdl/pcf_pkg.sv
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants of the pixel colour filter.
// ---------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

    localparam int PixelWidth    = 32;
    localparam int ChanWidth     = 8;
    localparam int ModeWidth     = 3;
    localparam int OffsetWidth   = 9;
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 9;

    localparam logic [ModeWidth-1:0] MODE_INVERT    = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_MONO      = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_NIGHT     = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_THRESHOLD = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_OFFSET    = 3'd4;

    localparam logic [CfgIndexWidth-1:0] REG_FILTER_MODE     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_RED_THRESHOLD   = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_GREEN_THRESHOLD = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_BLUE_THRESHOLD  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_RED_OFFSET      = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_GREEN_OFFSET    = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_BLUE_OFFSET     = 3'd6;

    typedef struct packed {
        logic [ModeWidth-1:0]          filter_mode;
        logic [ChanWidth-1:0]          red_threshold;
        logic [ChanWidth-1:0]          green_threshold;
        logic [ChanWidth-1:0]          blue_threshold;
        logic signed [OffsetWidth-1:0] red_offset;
        logic signed [OffsetWidth-1:0] green_offset;
        logic signed [OffsetWidth-1:0] blue_offset;
    } cfg_t;

endpackage

`default_nettype wire

### hdl/pcf_cfg_regs.sv
// ---------------------------------------------------------------------------
// pcf_cfg_regs
// Configuration register file; one write request per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pcf_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pcf_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [pcf_pkg::CfgDataWidth-1:0]   cfg_data,
    output pcf_pkg::cfg_t                           cfg
);
    import pcf_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILTER_MODE:     cfg_next.filter_mode     = cfg_data[ModeWidth-1:0];
                REG_RED_THRESHOLD:   cfg_next.red_threshold   = cfg_data[ChanWidth-1:0];
                REG_GREEN_THRESHOLD: cfg_next.green_threshold = cfg_data[ChanWidth-1:0];
                REG_BLUE_THRESHOLD:  cfg_next.blue_threshold  = cfg_data[ChanWidth-1:0];
                REG_RED_OFFSET:      cfg_next.red_offset      = cfg_data[OffsetWidth-1:0];
                REG_GREEN_OFFSET:    cfg_next.green_offset    = cfg_data[OffsetWidth-1:0];
                REG_BLUE_OFFSET:     cfg_next.blue_offset     = cfg_data[OffsetWidth-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pcf_point_op.sv
// ---------------------------------------------------------------------------
// pcf_point_op
// Combinational per-pixel colour operation; alpha passes through.
// ---------------------------------------------------------------------------
`default_nettype none

module pcf_point_op (
    input  pcf_pkg::cfg_t                          cfg,
    input  wire logic [pcf_pkg::PixelWidth-1:0]    pixel_in,
    output logic [pcf_pkg::PixelWidth-1:0]         pixel_out
);
    import pcf_pkg::*;

    localparam int SumWidth   = ChanWidth + 2;
    localparam int ProdWidth  = 2 * SumWidth;
    localparam int RecipShift = 11;
    // ceil(2^11 / 3); exact floor division by 3 for sums up to 765
    localparam logic [SumWidth-1:0] Recip3 = SumWidth'(((1 << RecipShift) + 2) / 3);

    logic [ChanWidth-1:0] r;
    logic [ChanWidth-1:0] g;
    logic [ChanWidth-1:0] b;
    logic [ChanWidth-1:0] a;
    logic [SumWidth-1:0]  sum;
    logic [ProdWidth-1:0] prod;
    logic [ChanWidth-1:0] mean;
    logic [ChanWidth-1:0] r_out;
    logic [ChanWidth-1:0] g_out;
    logic [ChanWidth-1:0] b_out;

    function automatic logic [ChanWidth-1:0] clamp_add(
        input logic [ChanWidth-1:0]          c,
        input logic signed [OffsetWidth-1:0] off
    );
        logic signed [SumWidth-1:0] s;
        s = $signed({2'b00, c}) + SumWidth'(off);
        if (s[SumWidth-1])
        begin
            return '0;
        end
        else if (s[SumWidth-2])
        begin
            return '1;
        end
        return s[ChanWidth-1:0];
    endfunction

    assign r    = pixel_in[31:24];
    assign g    = pixel_in[23:16];
    assign b    = pixel_in[15:8];
    assign a    = pixel_in[7:0];
    assign sum  = SumWidth'(r) + SumWidth'(g) + SumWidth'(b);
    assign prod = ProdWidth'(sum) * ProdWidth'(Recip3);
    assign mean = prod[RecipShift+ChanWidth-1:RecipShift];

    always_comb
    begin
        r_out = r;
        g_out = g;
        b_out = b;
        case (cfg.filter_mode)
            MODE_INVERT:
            begin
                r_out = ~r;
                g_out = ~g;
                b_out = ~b;
            end
            MODE_MONO:
            begin
                r_out = mean;
                g_out = mean;
                b_out = mean;
            end
            MODE_NIGHT:
            begin
                r_out = '0;
                g_out = mean;
                b_out = '0;
            end
            MODE_THRESHOLD:
            begin
                r_out = (r < cfg.red_threshold)   ? '0 : r;
                g_out = (g < cfg.green_threshold) ? '0 : g;
                b_out = (b < cfg.blue_threshold)  ? '0 : b;
            end
            MODE_OFFSET:
            begin
                r_out = clamp_add(r, cfg.red_offset);
                g_out = clamp_add(g, cfg.green_offset);
                b_out = clamp_add(b, cfg.blue_offset);
            end
            default:
            begin
                r_out = r;
                g_out = g;
                b_out = b;
            end
        endcase
    end

    assign pixel_out = {r_out, g_out, b_out, a};

endmodule

`default_nettype wire

### hdl/pixel_color_filter_top.sv
// ---------------------------------------------------------------------------
// pixel_color_filter_top
// RGBA8888 colour point operation filter: invert, monochrome, night vision,
// threshold and clamped offset; alpha passes through.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------
//  input    | start, busy             | pixel_in
//  result   | done (strobe)           | pixel_out
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
//  One request per cycle; busy stays low. Path: input register, filter logic,
//  result register. done is high for one cycle per request.
//  Async active-low reset clears the config registers and the valid flags;
//  the pixel data registers are not reset.
//  The receiver cannot stall; results are never held.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pixel_color_filter_top_defines.svh"

module pixel_color_filter_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [pcf_pkg::PixelWidth-1:0]     pixel_in,
    output logic                                    done,
    output logic [pcf_pkg::PixelWidth-1:0]          pixel_out,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pcf_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [pcf_pkg::CfgDataWidth-1:0]   cfg_data
);
    import pcf_pkg::*;

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [PixelWidth-1:0] in_pixel_reg;
    logic                  done_reg;
    logic [PixelWidth-1:0] out_pixel_reg;
    logic [PixelWidth-1:0] out_pixel_next;

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign pixel_out = out_pixel_reg;

    pcf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcf_point_op u_point_op (
        .cfg       (cfg),
        .pixel_in  (in_pixel_reg),
        .pixel_out (out_pixel_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_pixel_reg <= pixel_in;
        end
        if (in_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    `PCF_ASSERT_DLY2(a_req_gives_done, clk, rst_n, start && !busy, done, "request without result")
    `PCF_ASSERT_IMPL(a_done_has_req, clk, rst_n, done, $past(start && !busy, 2), "spurious result")
    `PCF_ASSERT_IMPL(a_alpha_kept, clk, rst_n, done, pixel_out[7:0] == $past(pixel_in[7:0], 2), "alpha changed")

endmodule

`default_nettype wire
